// ===== rtl/cfb_pkg.sv =====
`timescale 1ns / 1ps

package cfb_pkg;

   localparam int TIME_W      = 32;
   localparam int WINDOW_W    = 16;
   localparam int COUNT_W     = 4;
   localparam int USED_OUT_W  = 6;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT  = CSR_INDEX_W'(1);

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(180);
   localparam logic [COUNT_W-1:0]  LIMIT_RESET  = COUNT_W'(3);
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = COUNT_W'(15);
   localparam logic [COUNT_W-1:0]  COUNT_ONE    = COUNT_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// ===== rtl/change_frequency_blacklist.sv =====
`timescale 1ns / 1ps

// A request word is taken only while idle; the block then scans every entry of the memory
// and presents the response word, held back while a still stalled earlier response waits.
// No new request word is taken until that response word is registered, as the scan of the
// entry memory reads one entry per cycle for aging, lookup and victim choice.
// Reset (synchronous, active high) clears all valid bits and the entry count at once and
// restores the window to 180 seconds and the change limit to 3.
module change_frequency_blacklist #(
   parameter int TABLE_ENTRIES = 32,
   parameter int KEY_BITS      = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [cfb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cfb_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [KEY_BITS-1:0]                  req_key,
   input  logic [cfb_pkg::TIME_W-1:0]           req_now_seconds,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_blacklisted,
   output logic                                 rsp_newly_tracked,
   output logic                                 rsp_evicted,
   output logic [cfb_pkg::COUNT_W-1:0]          rsp_change_count,
   output logic [cfb_pkg::USED_OUT_W-1:0]       rsp_entries_in_use
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int USE_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_W = KEY_BITS + cfb_pkg::TIME_W + cfb_pkg::COUNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   cfb_pkg::state_type state_ff, state_in;

   logic [cfb_pkg::WINDOW_W-1:0] window_ff;
   logic [cfb_pkg::COUNT_W-1:0]  limit_ff;

   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic                       proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]           proc_idx_ff, proc_idx_in;
   logic [TABLE_ENTRIES-1:0]   valid_ff, valid_in;
   logic [USE_W-1:0]           used_ff, used_in;
   logic [KEY_BITS-1:0]        key_ff, key_in;
   logic [cfb_pkg::TIME_W-1:0] now_ff, now_in;

   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [cfb_pkg::COUNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [cfb_pkg::TIME_W-1:0]  hit_time_ff, hit_time_in;
   logic                        free_ff, free_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic                        best_any_ff, best_any_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   logic [cfb_pkg::COUNT_W-1:0] best_cnt_ff, best_cnt_in;
   logic [cfb_pkg::TIME_W-1:0]  best_age_ff, best_age_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_black_ff, rsp_black_in;
   logic                           rsp_fresh_ff, rsp_fresh_in;
   logic                           rsp_evict_ff, rsp_evict_in;
   logic [cfb_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [cfb_pkg::USED_OUT_W-1:0] rsp_used_ff, rsp_used_in;

   logic [KEY_BITS-1:0]         rd_key;
   logic [cfb_pkg::TIME_W-1:0]  rd_time;
   logic [cfb_pkg::COUNT_W-1:0] rd_cnt;
   logic [cfb_pkg::TIME_W-1:0]  rd_age;
   logic                        rd_expire;
   logic                        rd_live;
   logic [cfb_pkg::COUNT_W-1:0] cnt_new;
   logic                        black;
   logic [IDX_W-1:0]            target;

   assign rd_key    = rd_data_ff[ENTRY_W-1 -: KEY_BITS];
   assign rd_time   = rd_data_ff[cfb_pkg::COUNT_W +: cfb_pkg::TIME_W];
   assign rd_cnt    = rd_data_ff[cfb_pkg::COUNT_W-1:0];
   assign rd_age    = now_ff - rd_time;
   assign rd_expire = valid_ff[proc_idx_ff] && (rd_age > cfb_pkg::TIME_W'(window_ff));
   assign rd_live   = valid_ff[proc_idx_ff] && !rd_expire;

   assign cnt_new = (hit_cnt_ff == cfb_pkg::COUNT_MAX) ? hit_cnt_ff
                                                       : hit_cnt_ff + cfb_pkg::COUNT_ONE;
   assign black   = cnt_new >= limit_ff;
   assign target  = free_ff ? free_idx_ff : best_idx_ff;

   assign req_stall          = (state_ff != cfb_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_blacklisted    = rsp_black_ff;
   assign rsp_newly_tracked  = rsp_fresh_ff;
   assign rsp_evicted        = rsp_evict_ff;
   assign rsp_change_count   = rsp_count_ff;
   assign rsp_entries_in_use = rsp_used_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      proc_valid_in = 1'b0;
      proc_idx_in   = idx_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_cnt_in    = hit_cnt_ff;
      hit_time_in   = hit_time_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_any_in   = best_any_ff;
      best_idx_in   = best_idx_ff;
      best_cnt_in   = best_cnt_ff;
      best_age_in   = best_age_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_black_in  = rsp_black_ff;
      rsp_fresh_in  = rsp_fresh_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_used_in   = rsp_used_ff;
      mem_we        = 1'b0;
      mem_waddr     = target;
      mem_wdata     = {key_ff, now_ff, cfb_pkg::COUNT_ONE};

      // One entry per cycle: drop it if too old; a live entry is tried for a match and as the
      // eviction victim, a dead one (invalid or just dropped) for a free slot.
      if (proc_valid_ff) begin
         if (rd_expire) begin
            valid_in[proc_idx_ff] = 1'b0;
            used_in               = used_ff - USE_W'(1);
         end
         if (rd_live && (rd_key == key_ff) && !hit_ff) begin
            hit_in      = 1'b1;
            hit_idx_in  = proc_idx_ff;
            hit_cnt_in  = rd_cnt;
            hit_time_in = rd_time;
         end
         if (!rd_live && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = proc_idx_ff;
         end
         if (rd_live && (!best_any_ff || (rd_cnt < best_cnt_ff) ||
                         ((rd_cnt == best_cnt_ff) && (rd_age > best_age_ff)))) begin
            best_any_in = 1'b1;
            best_idx_in = proc_idx_ff;
            best_cnt_in = rd_cnt;
            best_age_in = rd_age;
         end
      end

      case (state_ff)
         cfb_pkg::ST_IDLE: begin
            if (req_valid) begin
               key_in      = req_key;
               now_in      = req_now_seconds;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               best_any_in = 1'b0;
               idx_in      = '0;
               state_in    = cfb_pkg::ST_SCAN;
            end
         end
         cfb_pkg::ST_SCAN: begin
            proc_valid_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = cfb_pkg::ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         cfb_pkg::ST_DRAIN: begin
            state_in = cfb_pkg::ST_FINISH;
         end
         cfb_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               mem_we = 1'b1;
               if (hit_ff) begin
                  mem_waddr    = hit_idx_ff;
                  mem_wdata    = {key_ff, hit_time_ff, cnt_new};
                  rsp_black_in = black;
                  rsp_fresh_in = 1'b0;
                  rsp_evict_in = 1'b0;
                  rsp_count_in = cnt_new;
                  if (black) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     used_in              = used_ff - USE_W'(1);
                  end
               end else begin
                  valid_in[target] = 1'b1;
                  rsp_black_in     = 1'b0;
                  rsp_fresh_in     = 1'b1;
                  rsp_evict_in     = !free_ff;
                  rsp_count_in     = cfb_pkg::COUNT_ONE;
                  if (free_ff) begin
                     used_in = used_ff + USE_W'(1);
                  end
               end
               rsp_used_in  = cfb_pkg::USED_OUT_W'(used_in);
               rsp_valid_in = 1'b1;
               state_in     = cfb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cfb_pkg::ST_IDLE;
         proc_valid_ff <= 1'b0;
         valid_ff      <= '0;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         window_ff     <= cfb_pkg::WINDOW_RESET;
         limit_ff      <= cfb_pkg::LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         proc_valid_ff <= proc_valid_in;
         valid_ff      <= valid_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write && (csr_index == cfb_pkg::CSR_WINDOW)) begin
            window_ff <= csr_wdata[cfb_pkg::WINDOW_W-1:0];
         end
         if (csr_write && (csr_index == cfb_pkg::CSR_LIMIT)) begin
            limit_ff <= csr_wdata[cfb_pkg::COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      proc_idx_ff  <= proc_idx_in;
      key_ff       <= key_in;
      now_ff       <= now_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_cnt_ff   <= hit_cnt_in;
      hit_time_ff  <= hit_time_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      best_any_ff  <= best_any_in;
      best_idx_ff  <= best_idx_in;
      best_cnt_ff  <= best_cnt_in;
      best_age_ff  <= best_age_in;
      rsp_black_ff <= rsp_black_in;
      rsp_fresh_ff <= rsp_fresh_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_count_ff <= rsp_count_in;
      rsp_used_ff  <= rsp_used_in;
   end

endmodule
